// ===== hdl/mcu_pft_pkg.sv =====
// Shared types and constants of the peripheral register file with timer 1 and I/O ports.
package mcu_pft_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_PULSE = 2'd2,
    ACT_LINE  = 2'd3
  } action_t;

  localparam int unsigned NumRegs = 12;

  localparam logic [3:0] RegIocnt0  = 4'd0;
  localparam logic [3:0] RegTdata   = 4'd2;
  localparam logic [3:0] RegTctl    = 4'd3;
  localparam logic [3:0] RegPortA   = 4'd4;
  localparam logic [3:0] RegPortB   = 4'd6;
  localparam logic [3:0] RegPortC   = 4'd8;
  localparam logic [3:0] RegDirC    = 4'd9;
  localparam logic [3:0] RegPortD   = 4'd10;
  localparam logic [3:0] RegDirD    = 4'd11;

  localparam logic [7:0] IocW1c     = 8'h2a;
  localparam logic [7:0] IocEnInt1  = 8'h01;
  localparam logic [7:0] IocEnInt2  = 8'h04;
  localparam logic [7:0] IocEnInt3  = 8'h10;
  localparam logic [7:0] IocFlag1   = 8'h02;
  localparam int unsigned TctlEnBit  = 7;
  localparam int unsigned TctlExtBit = 6;

  localparam logic [1:0] LineInt1   = 2'd0;
  localparam logic [1:0] LineInt2   = 2'd1;
  localparam logic [1:0] LineInt3   = 2'd2;

  localparam logic [1:0] IrqNone    = 2'd0;
  localparam logic [1:0] IrqInt1    = 2'd1;
  localparam logic [1:0] IrqInt2    = 2'd2;
  localparam logic [1:0] IrqInt3    = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
    logic [1:0] line_index;
    logic       line_level;
    logic [7:0] port_a_pins;
    logic [7:0] port_c_pins;
    logic [7:0] port_d_pins;
    logic       global_enable;
  } item_t;

endpackage

// ===== hdl/mcu_peripheral_file_timer_ports.sv =====
// Top level: peripheral register file with I/O ports, event-counter timer 1 and interrupts.
// Each accepted input beat goes through the input register, then the result register, to its
// result beat; throughput one beat per cycle while out_stall is low, set by the single update stage.
// The input side keeps taking beats while a result waits, until both registers are full.
// Synchronous active-high reset clears the register file, counters, capture latch,
// line levels and both stage valids.
module mcu_peripheral_file_timer_ports (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [3:0] reg_offset,
  input  logic [7:0] write_data,
  input  logic [1:0] line_index,
  input  logic       line_level,
  input  logic [7:0] port_a_pins,
  input  logic [7:0] port_c_pins,
  input  logic [7:0] port_d_pins,
  input  logic       global_enable,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic [7:0] port_b_out,
  output logic [7:0] port_c_out,
  output logic [7:0] port_d_out,
  output logic [1:0] irq_request
);

  logic                  s1_valid;
  mcu_pft_pkg::item_t    s1;
  logic                  s1_advance;

  logic [7:0] regs [mcu_pft_pkg::NumRegs];
  logic [7:0] regs_next [mcu_pft_pkg::NumRegs];
  logic [4:0] prescale_count, prescale_count_next;
  logic [7:0] decrement_count, decrement_count_next;
  logic [7:0] capture_latch, capture_latch_next;
  logic [2:0] line_levels, line_levels_next;
  logic [7:0] rd_next;
  logic [1:0] irq_next;
  logic [7:0] flag;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1 <= '{action, reg_offset, write_data, line_index, line_level,
              port_a_pins, port_c_pins, port_d_pins, global_enable};
    end
  end

  always_comb begin
    regs_next            = regs;
    prescale_count_next  = prescale_count;
    decrement_count_next = decrement_count;
    capture_latch_next   = capture_latch;
    line_levels_next     = line_levels;
    rd_next              = 8'h00;
    flag                 = mcu_pft_pkg::IocFlag1 << {s1.line_index, 1'b0};
    case (mcu_pft_pkg::action_t'(s1.action))
      mcu_pft_pkg::ACT_READ: begin
        if (32'(s1.reg_offset) < mcu_pft_pkg::NumRegs) begin
          unique case (s1.reg_offset)
            mcu_pft_pkg::RegTdata: rd_next = decrement_count;
            mcu_pft_pkg::RegTctl:  rd_next = capture_latch;
            mcu_pft_pkg::RegPortA: rd_next = s1.port_a_pins;
            mcu_pft_pkg::RegPortC: begin
              rd_next = (regs[mcu_pft_pkg::RegPortC] & regs[mcu_pft_pkg::RegDirC]) |
                        (s1.port_c_pins & ~regs[mcu_pft_pkg::RegDirC]);
            end
            mcu_pft_pkg::RegPortD: begin
              rd_next = (regs[mcu_pft_pkg::RegPortD] & regs[mcu_pft_pkg::RegDirD]) |
                        (s1.port_d_pins & ~regs[mcu_pft_pkg::RegDirD]);
            end
            default: rd_next = regs[s1.reg_offset];
          endcase
        end
      end
      mcu_pft_pkg::ACT_WRITE: begin
        if (32'(s1.reg_offset) < mcu_pft_pkg::NumRegs) begin
          unique case (s1.reg_offset)
            mcu_pft_pkg::RegIocnt0: begin
              regs_next[mcu_pft_pkg::RegIocnt0] =
                (regs[mcu_pft_pkg::RegIocnt0] & mcu_pft_pkg::IocW1c &
                 ~(s1.write_data & mcu_pft_pkg::IocW1c)) |
                (s1.write_data & ~mcu_pft_pkg::IocW1c);
            end
            mcu_pft_pkg::RegTctl: begin
              regs_next[mcu_pft_pkg::RegTctl] = s1.write_data;
              if (s1.write_data[mcu_pft_pkg::TctlEnBit] &&
                  s1.write_data[mcu_pft_pkg::TctlExtBit]) begin
                prescale_count_next  = s1.write_data[4:0];
                decrement_count_next = regs[mcu_pft_pkg::RegTdata];
              end
            end
            mcu_pft_pkg::RegPortA: begin
            end
            mcu_pft_pkg::RegPortC: begin
              regs_next[mcu_pft_pkg::RegPortC] = s1.write_data & regs[mcu_pft_pkg::RegDirC];
            end
            mcu_pft_pkg::RegPortD: begin
              regs_next[mcu_pft_pkg::RegPortD] = s1.write_data & regs[mcu_pft_pkg::RegDirD];
            end
            default: regs_next[s1.reg_offset] = s1.write_data;
          endcase
        end
      end
      mcu_pft_pkg::ACT_PULSE: begin
        if (regs[mcu_pft_pkg::RegTctl][mcu_pft_pkg::TctlEnBit]) begin
          if (prescale_count != 5'd0) begin
            prescale_count_next = prescale_count - 5'd1;
          end else begin
            prescale_count_next = regs[mcu_pft_pkg::RegTctl][4:0];
            if (decrement_count != 8'h00) begin
              decrement_count_next = decrement_count - 8'd1;
            end else begin
              // underflow: reload and raise INT2
              decrement_count_next = regs[mcu_pft_pkg::RegTdata];
              line_levels_next[1] = 1'b1;
              regs_next[mcu_pft_pkg::RegIocnt0] =
                regs[mcu_pft_pkg::RegIocnt0] | (mcu_pft_pkg::IocFlag1 << 2);
            end
          end
        end
      end
      mcu_pft_pkg::ACT_LINE: begin
        if (s1.line_index == mcu_pft_pkg::LineInt1 ||
            s1.line_index == mcu_pft_pkg::LineInt2 ||
            s1.line_index == mcu_pft_pkg::LineInt3) begin
          line_levels_next[s1.line_index] = s1.line_level;
          if (s1.line_level) begin
            regs_next[mcu_pft_pkg::RegIocnt0] = regs[mcu_pft_pkg::RegIocnt0] | flag;
            if (s1.line_index == mcu_pft_pkg::LineInt3) begin
              capture_latch_next = decrement_count;
            end
          end else begin
            regs_next[mcu_pft_pkg::RegIocnt0] = regs[mcu_pft_pkg::RegIocnt0] & ~flag;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    irq_next = mcu_pft_pkg::IrqNone;
    if (s1.global_enable) begin
      if (line_levels_next[0] &&
          ((regs_next[mcu_pft_pkg::RegIocnt0] & mcu_pft_pkg::IocEnInt1) != 8'h00)) begin
        irq_next = mcu_pft_pkg::IrqInt1;
      end else if (line_levels_next[1] &&
          ((regs_next[mcu_pft_pkg::RegIocnt0] & mcu_pft_pkg::IocEnInt2) != 8'h00)) begin
        irq_next = mcu_pft_pkg::IrqInt2;
      end else if (line_levels_next[2] &&
          ((regs_next[mcu_pft_pkg::RegIocnt0] & mcu_pft_pkg::IocEnInt3) != 8'h00)) begin
        irq_next = mcu_pft_pkg::IrqInt3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mcu_pft_pkg::NumRegs; i++) begin
        regs[i] <= 8'h00;
      end
      prescale_count  <= 5'd0;
      decrement_count <= 8'h00;
      capture_latch   <= 8'h00;
      line_levels     <= 3'b000;
    end else if (s1_advance) begin
      regs            <= regs_next;
      prescale_count  <= prescale_count_next;
      decrement_count <= decrement_count_next;
      capture_latch   <= capture_latch_next;
      line_levels     <= line_levels_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      read_data   <= rd_next;
      port_b_out  <= regs_next[mcu_pft_pkg::RegPortB];
      port_c_out  <= regs_next[mcu_pft_pkg::RegPortC];
      port_d_out  <= regs_next[mcu_pft_pkg::RegPortD];
      irq_request <= irq_next;
    end
  end

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with a free stage");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("advanced beat lost before result register");

  a_held_stage_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1)))
    else $error("held input stage changed");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!s1_valid && !out_valid))
    else $error("stages not empty after reset");

  a_irq_needs_enable: assert property (@(posedge clk) disable iff (rst)
    s1_advance && !s1.global_enable |=> (irq_request == mcu_pft_pkg::IrqNone))
    else $error("interrupt requested while globally disabled");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the peripheral register file with ports, timer 1 and interrupts.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [3:0] RegBeyond  = 4'd15;
  localparam logic [1:0] LineNone   = 2'd3;
  localparam logic [7:0] PrescMask  = 8'h1f;
  localparam int unsigned NumRandom = 725;
  localparam int unsigned HoldAt    = 300;
  localparam int unsigned HoldLen   = 60;
  localparam int unsigned CalmFrom  = 400;
  localparam int unsigned CalmTo    = 560;

  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] pb;
    logic [7:0] pc;
    logic [7:0] pd;
    logic [1:0] irq;
  } view_t;

  typedef struct {
    mcu_pft_pkg::item_t it;
    bit                 pinned;
    view_t              want;
  } row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  out_stall = 1'b0;
  mcu_pft_pkg::item_t cur = '0;
  logic  in_stall;
  logic  out_valid;
  logic [7:0] read_data;
  logic [7:0] port_b_out;
  logic [7:0] port_c_out;
  logic [7:0] port_d_out;
  logic [1:0] irq_request;

  logic [7:0] pf_regs [mcu_pft_pkg::NumRegs];
  logic [7:0] presc_cnt = '0;
  logic [7:0] down_cnt = '0;
  logic [7:0] capt_latch = '0;
  logic [2:0] line_lvl = '0;

  view_t       awaited_views[$];
  row_t        plan [26];
  int unsigned beats_in = 0;
  int unsigned errors = 0;
  bit          calm = 1'b0;

  mcu_peripheral_file_timer_ports u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (cur.action),
    .reg_offset   (cur.reg_offset),
    .write_data   (cur.write_data),
    .line_index   (cur.line_index),
    .line_level   (cur.line_level),
    .port_a_pins  (cur.port_a_pins),
    .port_c_pins  (cur.port_c_pins),
    .port_d_pins  (cur.port_d_pins),
    .global_enable(cur.global_enable),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .port_b_out   (port_b_out),
    .port_c_out   (port_c_out),
    .port_d_out   (port_d_out),
    .irq_request  (irq_request)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic drive_line(input logic [1:0] idx, input logic lvl);
    logic [7:0] flag;
    flag = mcu_pft_pkg::IocFlag1 << (2 * idx);
    if (lvl) begin
      line_lvl[idx] = 1'b1;
      pf_regs[mcu_pft_pkg::RegIocnt0] = pf_regs[mcu_pft_pkg::RegIocnt0] | flag;
      if (idx == mcu_pft_pkg::LineInt3) capt_latch = down_cnt;
    end else begin
      line_lvl[idx] = 1'b0;
      pf_regs[mcu_pft_pkg::RegIocnt0] = pf_regs[mcu_pft_pkg::RegIocnt0] & ~flag;
    end
  endtask

  task automatic step_file(input mcu_pft_pkg::item_t it, output view_t v);
    logic [3:0] off;
    logic [7:0] wd;
    off = it.reg_offset;
    wd  = it.write_data;
    v   = '0;
    case (it.action)
      mcu_pft_pkg::ACT_READ: begin
        if (off < mcu_pft_pkg::NumRegs) begin
          case (off)
            mcu_pft_pkg::RegTdata: v.rd = down_cnt;
            mcu_pft_pkg::RegTctl:  v.rd = capt_latch;
            mcu_pft_pkg::RegPortA: v.rd = it.port_a_pins;
            mcu_pft_pkg::RegPortC: begin
              v.rd = (pf_regs[mcu_pft_pkg::RegPortC] & pf_regs[mcu_pft_pkg::RegDirC]) |
                     (it.port_c_pins & ~pf_regs[mcu_pft_pkg::RegDirC]);
            end
            mcu_pft_pkg::RegPortD: begin
              v.rd = (pf_regs[mcu_pft_pkg::RegPortD] & pf_regs[mcu_pft_pkg::RegDirD]) |
                     (it.port_d_pins & ~pf_regs[mcu_pft_pkg::RegDirD]);
            end
            default:  v.rd = pf_regs[off];
          endcase
        end
      end
      mcu_pft_pkg::ACT_WRITE: begin
        if (off < mcu_pft_pkg::NumRegs) begin
          case (off)
            mcu_pft_pkg::RegIocnt0: begin
              pf_regs[mcu_pft_pkg::RegIocnt0] =
                (pf_regs[mcu_pft_pkg::RegIocnt0] & mcu_pft_pkg::IocW1c &
                 ~(wd & mcu_pft_pkg::IocW1c)) | (wd & ~mcu_pft_pkg::IocW1c);
            end
            mcu_pft_pkg::RegTctl: begin
              pf_regs[mcu_pft_pkg::RegTctl] = wd;
              if (wd[mcu_pft_pkg::TctlEnBit] && wd[mcu_pft_pkg::TctlExtBit]) begin
                presc_cnt = wd & PrescMask;
                down_cnt  = pf_regs[mcu_pft_pkg::RegTdata];
              end
            end
            mcu_pft_pkg::RegPortA: ;
            mcu_pft_pkg::RegPortC: begin
              pf_regs[mcu_pft_pkg::RegPortC] = wd & pf_regs[mcu_pft_pkg::RegDirC];
            end
            mcu_pft_pkg::RegPortD: begin
              pf_regs[mcu_pft_pkg::RegPortD] = wd & pf_regs[mcu_pft_pkg::RegDirD];
            end
            default:  pf_regs[off] = wd;
          endcase
        end
      end
      mcu_pft_pkg::ACT_PULSE: begin
        if (pf_regs[mcu_pft_pkg::RegTctl][mcu_pft_pkg::TctlEnBit]) begin
          presc_cnt = presc_cnt - 8'd1;
          if (presc_cnt == 8'hff) begin
            presc_cnt = pf_regs[mcu_pft_pkg::RegTctl] & PrescMask;
            down_cnt  = down_cnt - 8'd1;
            if (down_cnt == 8'hff) begin
              down_cnt = pf_regs[mcu_pft_pkg::RegTdata];
              drive_line(mcu_pft_pkg::LineInt2, 1'b1);
            end
          end
        end
      end
      default: begin
        if (it.line_index != LineNone) drive_line(it.line_index, it.line_level);
      end
    endcase
    if (it.global_enable) begin
      if (line_lvl[0] && (pf_regs[mcu_pft_pkg::RegIocnt0] & mcu_pft_pkg::IocEnInt1) != 0)
        v.irq = mcu_pft_pkg::IrqInt1;
      else if (line_lvl[1] && (pf_regs[mcu_pft_pkg::RegIocnt0] & mcu_pft_pkg::IocEnInt2) != 0)
        v.irq = mcu_pft_pkg::IrqInt2;
      else if (line_lvl[2] && (pf_regs[mcu_pft_pkg::RegIocnt0] & mcu_pft_pkg::IocEnInt3) != 0)
        v.irq = mcu_pft_pkg::IrqInt3;
    end
    v.pb = pf_regs[mcu_pft_pkg::RegPortB];
    v.pc = pf_regs[mcu_pft_pkg::RegPortC];
    v.pd = pf_regs[mcu_pft_pkg::RegPortD];
  endtask

  task automatic send_beat(input mcu_pft_pkg::item_t it, input bit pinned, input view_t want);
    view_t got;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cur <= it;
    do @(posedge clk); while (in_stall);
    step_file(it, got);
    awaited_views.push_back(pinned ? want : got);
    beats_in++;
  endtask

  initial begin : stimulus
    mcu_pft_pkg::item_t it;
    int unsigned        r;
    foreach (pf_regs[i]) pf_regs[i] = '0;
    plan = '{
      '{'{mcu_pft_pkg::ACT_READ,  mcu_pft_pkg::RegIocnt0, 'h00, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        1, '{'h00, 'h00, 'h00, 'h00, mcu_pft_pkg::IrqNone}},
      '{'{mcu_pft_pkg::ACT_PULSE, mcu_pft_pkg::RegIocnt0, 'h00, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        1, '{'h00, 'h00, 'h00, 'h00, mcu_pft_pkg::IrqNone}},
      '{'{mcu_pft_pkg::ACT_READ,  mcu_pft_pkg::RegPortA,  'h00, mcu_pft_pkg::LineInt1, 0,
          'hff, 'h00, 'h00, 1},
        1, '{'hff, 'h00, 'h00, 'h00, mcu_pft_pkg::IrqNone}},
      '{'{mcu_pft_pkg::ACT_READ,  RegBeyond,              'h00, mcu_pft_pkg::LineInt1, 0,
          'hff, 'hff, 'hff, 1},
        1, '{'h00, 'h00, 'h00, 'h00, mcu_pft_pkg::IrqNone}},
      '{'{mcu_pft_pkg::ACT_WRITE, RegBeyond,              'hff, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        1, '{'h00, 'h00, 'h00, 'h00, mcu_pft_pkg::IrqNone}},
      '{'{mcu_pft_pkg::ACT_WRITE, mcu_pft_pkg::RegPortB,  'hff, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        1, '{'h00, 'hff, 'h00, 'h00, mcu_pft_pkg::IrqNone}},
      '{'{mcu_pft_pkg::ACT_WRITE, mcu_pft_pkg::RegDirC,   'hf0, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        0, '0},
      '{'{mcu_pft_pkg::ACT_WRITE, mcu_pft_pkg::RegPortC,  'hff, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        1, '{'h00, 'hff, 'hf0, 'h00, mcu_pft_pkg::IrqNone}},
      '{'{mcu_pft_pkg::ACT_READ,  mcu_pft_pkg::RegPortC,  'h00, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h5a, 'h00, 1},
        1, '{'hfa, 'hff, 'hf0, 'h00, mcu_pft_pkg::IrqNone}},
      '{'{mcu_pft_pkg::ACT_WRITE, mcu_pft_pkg::RegDirD,   'h0f, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        0, '0},
      '{'{mcu_pft_pkg::ACT_WRITE, mcu_pft_pkg::RegPortD,  'hff, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        1, '{'h00, 'hff, 'hf0, 'h0f, mcu_pft_pkg::IrqNone}},
      '{'{mcu_pft_pkg::ACT_READ,  mcu_pft_pkg::RegPortD,  'h00, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'ha5, 1},
        1, '{'haf, 'hff, 'hf0, 'h0f, mcu_pft_pkg::IrqNone}},
      '{'{mcu_pft_pkg::ACT_WRITE, mcu_pft_pkg::RegPortA,  'hff, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        0, '0},
      '{'{mcu_pft_pkg::ACT_WRITE, mcu_pft_pkg::RegIocnt0, 'hff, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        0, '0},
      '{'{mcu_pft_pkg::ACT_LINE,  mcu_pft_pkg::RegIocnt0, 'h00, mcu_pft_pkg::LineInt1, 1,
          'h00, 'h00, 'h00, 1},
        1, '{'h00, 'hff, 'hf0, 'h0f, mcu_pft_pkg::IrqInt1}},
      '{'{mcu_pft_pkg::ACT_READ,  mcu_pft_pkg::RegIocnt0, 'h00, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 0},
        1, '{'hd7, 'hff, 'hf0, 'h0f, mcu_pft_pkg::IrqNone}},
      '{'{mcu_pft_pkg::ACT_LINE,  mcu_pft_pkg::RegIocnt0, 'h00, mcu_pft_pkg::LineInt3, 1,
          'h00, 'h00, 'h00, 1},
        0, '0},
      '{'{mcu_pft_pkg::ACT_LINE,  mcu_pft_pkg::RegIocnt0, 'h00, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        1, '{'h00, 'hff, 'hf0, 'h0f, mcu_pft_pkg::IrqInt3}},
      '{'{mcu_pft_pkg::ACT_LINE,  mcu_pft_pkg::RegIocnt0, 'h00, LineNone,             1,
          'h00, 'h00, 'h00, 1},
        0, '0},
      '{'{mcu_pft_pkg::ACT_WRITE, mcu_pft_pkg::RegIocnt0, 'h20, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        0, '0},
      '{'{mcu_pft_pkg::ACT_WRITE, mcu_pft_pkg::RegIocnt0, 'h15, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        0, '0},
      '{'{mcu_pft_pkg::ACT_WRITE, mcu_pft_pkg::RegTdata,  'h01, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        0, '0},
      '{'{mcu_pft_pkg::ACT_WRITE, mcu_pft_pkg::RegTctl,   'hc0, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        0, '0},
      '{'{mcu_pft_pkg::ACT_PULSE, mcu_pft_pkg::RegIocnt0, 'h00, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        0, '0},
      '{'{mcu_pft_pkg::ACT_PULSE, mcu_pft_pkg::RegIocnt0, 'h00, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        0, '0},
      '{'{mcu_pft_pkg::ACT_READ,  mcu_pft_pkg::RegTdata,  'h00, mcu_pft_pkg::LineInt1, 0,
          'h00, 'h00, 'h00, 1},
        0, '0}
    };
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_beat(plan[i].it, plan[i].pinned, plan[i].want);

    for (int unsigned n = 0; n < NumRandom; n++) begin
      calm = (n >= CalmFrom && n < CalmTo);
      r = $urandom_range(0, 99);
      it.action = (r < 30) ? mcu_pft_pkg::ACT_READ :
                  (r < 60) ? mcu_pft_pkg::ACT_WRITE :
                  (r < 85) ? mcu_pft_pkg::ACT_PULSE : mcu_pft_pkg::ACT_LINE;
      it.reg_offset = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                                   : 4'($urandom_range(0, 11));
      it.write_data = 8'($urandom);
      if (it.reg_offset == mcu_pft_pkg::RegTctl && $urandom_range(0, 2) != 0)
        it.write_data = ($urandom_range(0, 7) == 0) ? 8'hdf : 8'hc0 | 8'($urandom_range(0, 3));
      if (it.reg_offset == mcu_pft_pkg::RegTdata && $urandom_range(0, 2) != 0)
        it.write_data = 8'($urandom_range(0, 3));
      it.line_index    = ($urandom_range(0, 15) == 0) ? LineNone : 2'($urandom_range(0, 2));
      it.line_level    = 1'($urandom);
      it.port_a_pins   = 8'($urandom);
      it.port_c_pins   = 8'($urandom);
      it.port_d_pins   = 8'($urandom);
      it.global_enable = ($urandom_range(0, 4) != 0);
      send_beat(it, 1'b0, '0);
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // hold off once for a long stretch so the block fills and stalls its input
  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && beats_in >= HoldAt) begin
        held      = 1'b1;
        hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (!calm && $urandom_range(0, 99) < 29);
      end
    end
  end

  always @(posedge clk) begin
    view_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_views.size() == 0) begin
        $error("result beat with nothing awaited");
        errors++;
      end else begin
        want = awaited_views.pop_front();
        if (read_data !== want.rd) begin
          $error("read_data: expected %02h, got %02h", want.rd, read_data);
          errors++;
        end
        if (port_b_out !== want.pb) begin
          $error("port_b_out: expected %02h, got %02h", want.pb, port_b_out);
          errors++;
        end
        if (port_c_out !== want.pc) begin
          $error("port_c_out: expected %02h, got %02h", want.pc, port_c_out);
          errors++;
        end
        if (port_d_out !== want.pd) begin
          $error("port_d_out: expected %02h, got %02h", want.pd, port_d_out);
          errors++;
        end
        if (irq_request !== want.irq) begin
          $error("irq_request: expected %0d, got %0d", want.irq, irq_request);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
